// ----- sv/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants for the double-ended queue
// Command and status codes, field widths and capacity limits.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned ValueW   = 32;
  localparam int unsigned CapW     = 16;
  localparam int unsigned CountOutW = 5;
  localparam int unsigned CfgW     = 5;

  localparam logic [CapW-1:0] CapMax   = 16'hFFFF;
  localparam logic [CapW-1:0] CapReset = 16'd4;
  localparam logic [CfgW-1:0] CfgReset = 5'd4;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

endpackage

// ----- sv/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue: deque of signed 32-bit words in a ring buffer
// Push/pop at either end or clear; every request returns one result with
// the popped word, status, size, tracked logical capacity and flags.
// ----------------------------------------------------------------------------
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------
//  in      | in_valid_i / in_ready_o    | command_i, value_i
//  out     | out_valid_o / out_ready_i  | popped_value_o, status_o,
//          |                            | item_count_o, logical_capacity_o,
//          |                            | is_empty_o, is_full_o
//  cfg     | cfg_we_i (no wait)         | cfg_wdata_i (initial capacity)
//
// One request per cycle unless stalled; each result shows the cycle after.
// Pointer, count and capacity update in one step at the accept edge; the
// ring buffer is written and read at that same edge, read data registered.
// Reset clears pointer, count, capacity (4), initial capacity (4) and the
// result valid flag; the ring buffer is not cleared and needs no sweep.
// A held result stalls input only when out_ready_i is low.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [dq_pkg::CfgW-1:0]              cfg_wdata_i,
  // request channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [2:0]                           command_i,
  input  logic signed [dq_pkg::ValueW-1:0]     value_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [dq_pkg::ValueW-1:0]     popped_value_o,
  output logic [1:0]                           status_o,
  output logic [dq_pkg::CountOutW-1:0]         item_count_o,
  output logic [dq_pkg::CapW-1:0]              logical_capacity_o,
  output logic                                 is_empty_o,
  output logic                                 is_full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);
  localparam logic [PtrW:0]   DepthS  = (PtrW + 1)'(DEPTH);
  localparam logic [CntW-1:0] DepthC  = CntW'(DEPTH);

  // state
  logic [PtrW-1:0]          front_q, front_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [dq_pkg::CapW-1:0]  cap_q, cap_d;
  logic [dq_pkg::CfgW-1:0]  init_cap_q;

  // ring buffer
  logic [dq_pkg::ValueW-1:0] mem [DEPTH];
  logic [dq_pkg::ValueW-1:0] rd_data_q;

  // result register
  logic                       out_valid_q;
  logic                       pop_ok_q;
  dq_pkg::status_e            status_q;
  logic [dq_pkg::CountOutW-1:0] count_out_q;
  logic [dq_pkg::CapW-1:0]    cap_out_q;
  logic                       empty_q, full_q;

  logic               accept;
  dq_pkg::cmd_e       cmd;
  dq_pkg::status_e    status_d;
  logic               wr_en, pop_ok;
  logic [PtrW-1:0]    wr_addr, rd_addr;
  logic [PtrW-1:0]    front_dec, front_inc, rear_push, rear_last;
  logic [PtrW:0]      sum_push, sum_last;
  logic [dq_pkg::CapW:0]   cap_x2;
  logic [dq_pkg::CapW-1:0] cap_grow, cap_half, cap_tmp;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign cmd        = dq_pkg::cmd_e'(command_i);

  // ring arithmetic: every sum stays below twice DEPTH
  assign front_dec = (front_q == '0) ? LastIdx : front_q - PtrW'(1);
  assign front_inc = (front_q == LastIdx) ? '0 : front_q + PtrW'(1);
  assign sum_push  = {1'b0, front_q} + (PtrW + 1)'(count_q);
  assign sum_last  = {1'b0, front_q} + (PtrW + 1)'(count_q) - (PtrW + 1)'(1);
  assign rear_push = (sum_push >= DepthS) ? PtrW'(sum_push - DepthS) : PtrW'(sum_push);
  assign rear_last = (sum_last >= DepthS) ? PtrW'(sum_last - DepthS) : PtrW'(sum_last);

  // capacity: doubling saturates, halving floors at one
  assign cap_x2   = {cap_q, 1'b0};
  assign cap_grow = (cap_x2 > {1'b0, dq_pkg::CapMax}) ? dq_pkg::CapMax
                                                      : cap_x2[dq_pkg::CapW-1:0];
  assign cap_half = cap_q >> 1;

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    cap_d    = cap_q;
    cap_tmp  = cap_q;
    status_d = dq_pkg::ST_DONE;
    wr_en    = 1'b0;
    wr_addr  = rear_push;
    rd_addr  = front_q;
    pop_ok   = 1'b0;
    case (cmd)
      dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_REAR: begin
        if (count_q >= DepthC) begin
          status_d = dq_pkg::ST_FULL;
        end else begin
          if (dq_pkg::CapW'(count_q) == cap_q) cap_d = cap_grow;
          wr_en   = 1'b1;
          count_d = count_q + CntW'(1);
          if (cmd == dq_pkg::CMD_PUSH_FRONT) begin
            front_d = front_dec;
            wr_addr = front_dec;
          end
        end
      end
      dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_REAR: begin
        if (count_q == '0) begin
          status_d = dq_pkg::ST_EMPTY;
        end else begin
          pop_ok  = 1'b1;
          count_d = count_q - CntW'(1);
          if (cmd == dq_pkg::CMD_POP_FRONT) begin
            front_d = front_inc;
          end else begin
            rd_addr = rear_last;
          end
          cap_tmp = (cap_half == '0) ? dq_pkg::CapW'(1) : cap_half;
          if (dq_pkg::CapW'(count_d) == cap_half) cap_d = cap_tmp;
        end
      end
      dq_pkg::CMD_CLEAR: begin
        front_d = '0;
        count_d = '0;
        cap_d   = (init_cap_q == '0) ? dq_pkg::CapW'(1) : dq_pkg::CapW'(init_cap_q);
      end
      default: begin
        // unused codes leave the state as it is
      end
    endcase
  end

  // ring buffer: at most one write and one read per request
  always_ff @(posedge clk_i) begin
    if (accept && wr_en) mem[wr_addr] <= value_i;
    if (accept) rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      cap_q       <= dq_pkg::CapReset;
      init_cap_q  <= dq_pkg::CfgReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) init_cap_q <= cfg_wdata_i;
      if (accept) begin
        front_q <= front_d;
        count_q <= count_d;
        cap_q   <= cap_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pop_ok_q    <= pop_ok;
      status_q    <= status_d;
      count_out_q <= dq_pkg::CountOutW'(count_d);
      cap_out_q   <= cap_d;
      empty_q     <= (count_d == '0);
      full_q      <= (count_d == DepthC);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign popped_value_o     = pop_ok_q ? rd_data_q : '0;
  assign status_o           = status_q;
  assign item_count_o       = count_out_q;
  assign logical_capacity_o = cap_out_q;
  assign is_empty_o         = empty_q;
  assign is_full_o          = full_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("held count above DEPTH");

  a_cap_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_q != '0)
    else $error("logical capacity reached zero");

  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == dq_pkg::ST_FULL |-> is_full_o)
    else $error("push rejected while store not full");

  a_empty_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == dq_pkg::ST_EMPTY |-> is_empty_o && popped_value_o == '0)
    else $error("pop rejected but deque not empty or word returned");

endmodule
